### rtl/lph_pkg.sv
// lph_pkg: widths, register indexes, mix constants and mix round functions
// for the landmark pair hash
// no dependencies
package lph_pkg;

    // widths of the fields and the quantised bin
    localparam int FREQ_W   = 24;
    localparam int DELTA_W  = 17;
    localparam int STEP_W   = 16;
    localparam int BIN_W    = 16;
    localparam int HASH_W   = 32;
    // non-negative dividend width (frequency magnitude without sign)
    localparam int NUM_W    = FREQ_W - 1;

    // divider pipeline shape
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = BIN_W / BITS_PER_STAGE;

    // pipeline stages: input, divider, three mix stages
    localparam int MIX_STAGES = 3;
    localparam int NUM_STAGES = 1 + DIV_STAGES + MIX_STAGES;

    typedef logic [BIN_W-1:0]  t_bin;
    typedef logic [HASH_W-1:0] t_word;
    typedef logic [NUM_W-1:0]  t_num;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_FREQ_STEP = 1'b0;
    localparam t_cfg_idx REG_TIME_STEP = 1'b1;

    // reset values of the step registers
    localparam logic [STEP_W-1:0] FREQ_STEP_RST = 16'd160;
    localparam logic [STEP_W-1:0] TIME_STEP_RST = 16'd10;

    // mix constants
    localparam t_word MIX_C0 = 32'h7ed55d16;
    localparam t_word MIX_C1 = 32'hc761c23c;
    localparam t_word MIX_C2 = 32'h165667b1;
    localparam t_word MIX_C3 = 32'hd3a2646c;
    localparam t_word MIX_C4 = 32'hfd7046c5;
    localparam t_word MIX_C5 = 32'hb55a4f09;

    // rounds one and two of the mix
    function automatic t_word mix_r12(input t_word a);
        t_word b;
        t_word c;
        b = (a + MIX_C0) + (a << 12);
        c = (b ^ MIX_C1) ^ (b >> 19);
        return c;
    endfunction

    // rounds three and four of the mix
    function automatic t_word mix_r34(input t_word a);
        t_word b;
        t_word c;
        b = (a + MIX_C2) + (a << 5);
        c = (b + MIX_C3) ^ (b << 9);
        return c;
    endfunction

    // rounds five and six of the mix
    function automatic t_word mix_r56(input t_word a);
        t_word b;
        t_word c;
        b = (a + MIX_C4) + (a << 3);
        c = (b ^ MIX_C5) ^ (b >> 16);
        return c;
    endfunction

endpackage

### rtl/lph_pair_if.sv
// lph_pair_if: valid/ready channel carrying one landmark pair word
// depends on lph_pkg for field widths
interface lph_pair_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lph_pkg::FREQ_W-1:0]    anc_freq;
    logic signed [lph_pkg::FREQ_W-1:0]    tgt_freq;
    logic signed [lph_pkg::DELTA_W-1:0]   delta_ms;

    modport source (output valid, output anc_freq, output tgt_freq,
                    output delta_ms, input ready);
    modport sink   (input valid, input anc_freq, input tgt_freq,
                    input delta_ms, output ready);
endinterface

### rtl/lph_hash_if.sv
// lph_hash_if: valid/ready channel carrying one hash word
// depends on lph_pkg for the hash width
interface lph_hash_if;
    logic                  valid;
    logic                  ready;
    lph_pkg::t_word        hash_word;

    modport source (output valid, output hash_word, input ready);
    modport sink   (input valid, input hash_word, output ready);
endinterface

### rtl/lph_div.sv
// lph_div: pipelined restoring divider for one lane, saturating the
// quotient at the bin maximum; stage loads are driven by the top level
// depends on lph_pkg
module lph_div (
    input  logic                           i_clk,
    input  logic [lph_pkg::DIV_STAGES:0]   i_adv,
    input  lph_pkg::t_num                  i_num,
    input  logic [lph_pkg::STEP_W-1:0]     i_step,
    output lph_pkg::t_bin                  o_quo
);
    localparam int LAST  = lph_pkg::DIV_STAGES;
    localparam int BW    = lph_pkg::BIN_W;
    localparam int HI_W  = lph_pkg::NUM_W - lph_pkg::BIN_W;

    // partial remainder, dividend bits still to shift in and quotient bits
    logic [BW-1:0] r_rem [0:LAST];
    logic [BW-1:0] r_acc [0:LAST];
    logic          r_sat [0:LAST];

    logic [BW-1:0] n_rem [1:LAST];
    logic [BW-1:0] n_acc [1:LAST];

    logic [BW-1:0] w_rem;
    logic [BW-1:0] w_acc;
    logic [BW:0]   w_try;
    logic [BW:0]   w_div;
    logic [BW-1:0] w_hi;

    assign w_div = {1'b0, i_step};
    assign w_hi  = {{(BW-HI_W){1'b0}}, i_num[lph_pkg::NUM_W-1:BW]};

    // two quotient bits per stage
    always_comb begin
        for (int k = 1; k <= LAST; k++) begin
            w_rem = r_rem[k-1];
            w_acc = r_acc[k-1];
            w_try = '0;
            for (int b = 0; b < lph_pkg::BITS_PER_STAGE; b++) begin
                w_try = {w_rem, w_acc[BW-1]};
                if (w_try >= w_div) begin
                    w_rem = BW'(w_try - w_div);
                    w_acc = {w_acc[BW-2:0], 1'b1};
                end else begin
                    w_rem = w_try[BW-1:0];
                    w_acc = {w_acc[BW-2:0], 1'b0};
                end
            end
            n_rem[k] = w_rem;
            n_acc[k] = w_acc;
        end
    end

    // entry stage: top bits start the remainder, overflow test up front;
    // then the divide stages
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_rem[0] <= w_hi;
            r_acc[0] <= i_num[BW-1:0];
            r_sat[0] <= (w_hi >= i_step);
        end
        for (int k = 1; k <= LAST; k++) begin
            if (i_adv[k]) begin
                r_rem[k] <= n_rem[k];
                r_acc[k] <= n_acc[k];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    // saturated quotient
    assign o_quo = r_sat[LAST] ? {BW{1'b1}} : r_acc[LAST];

endmodule

### rtl/landmark_pair_hash.sv
// landmark_pair_hash: throughput one word per cycle unless the output stalls;
// a 12-stage pipeline (input, eight divide stages of two quotient bits each,
// three mix stages of two rounds each).
// stages advance independently, so bubbles close up while the output stalls.
// synchronous active-low reset clears stage valids and sets the steps to
// 160 and 10; payload registers are not reset.
module landmark_pair_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  lph_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [lph_pkg::STEP_W-1:0]    i_cfg_data,
    lph_pair_if.sink                      i_pair,
    lph_hash_if.source                    o_hash
);
    localparam int NS    = lph_pkg::NUM_STAGES;
    localparam int DS    = lph_pkg::DIV_STAGES;
    localparam int BW    = lph_pkg::BIN_W;
    localparam int NW    = lph_pkg::NUM_W;

    // step registers, a zero write acts as one
    logic [lph_pkg::STEP_W-1:0] r_freq_step;
    logic [lph_pkg::STEP_W-1:0] r_time_step;
    logic [lph_pkg::STEP_W-1:0] n_step;

    assign n_step = (i_cfg_data == '0) ? lph_pkg::STEP_W'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_step <= lph_pkg::FREQ_STEP_RST;
            r_time_step <= lph_pkg::TIME_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lph_pkg::REG_FREQ_STEP: r_freq_step <= n_step;
                lph_pkg::REG_TIME_STEP: r_time_step <= n_step;
                default: ;
            endcase
        end
    end

    // stage valids and per-stage ready
    logic          r_vld [0:NS-1];
    logic [NS-1:0] w_rdy;

    always_comb begin
        w_rdy[NS-1] = !r_vld[NS-1] || o_hash.ready;
        for (int k = NS-2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_pair.valid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign i_pair.ready = w_rdy[0];

    // negative values give bin 0
    lph_pkg::t_num w_num_a;
    lph_pkg::t_num w_num_t;
    lph_pkg::t_num w_num_d;

    assign w_num_a = i_pair.anc_freq[NW] ? '0 : i_pair.anc_freq[NW-1:0];
    assign w_num_t = i_pair.tgt_freq[NW] ? '0 : i_pair.tgt_freq[NW-1:0];
    assign w_num_d = i_pair.delta_ms[lph_pkg::DELTA_W-1] ? '0 :
                     NW'(i_pair.delta_ms[lph_pkg::DELTA_W-2:0]);

    // three divider lanes
    lph_pkg::t_bin w_quo [0:2];

    lph_div u_div_anchor (
        .i_clk  (i_clk),
        .i_adv  (w_rdy[DS:0]),
        .i_num  (w_num_a),
        .i_step (r_freq_step),
        .o_quo  (w_quo[0])
    );

    lph_div u_div_target (
        .i_clk  (i_clk),
        .i_adv  (w_rdy[DS:0]),
        .i_num  (w_num_t),
        .i_step (r_freq_step),
        .o_quo  (w_quo[1])
    );

    lph_div u_div_delta (
        .i_clk  (i_clk),
        .i_adv  (w_rdy[DS:0]),
        .i_num  (w_num_d),
        .i_step (r_time_step),
        .o_quo  (w_quo[2])
    );

    // mix stages, two rounds each, xor folded into the last
    lph_pkg::t_word r_mix1 [0:2];
    lph_pkg::t_word r_mix2 [0:2];
    lph_pkg::t_word r_hash;

    always_ff @(posedge i_clk) begin
        if (w_rdy[DS+1]) begin
            for (int l = 0; l < 3; l++) begin
                r_mix1[l] <= lph_pkg::mix_r12({{(lph_pkg::HASH_W-BW){1'b0}}, w_quo[l]});
            end
        end
        if (w_rdy[DS+2]) begin
            for (int l = 0; l < 3; l++) begin
                r_mix2[l] <= lph_pkg::mix_r34(r_mix1[l]);
            end
        end
        if (w_rdy[DS+3]) begin
            r_hash <= lph_pkg::mix_r56(r_mix2[0]) ^ lph_pkg::mix_r56(r_mix2[1])
                    ^ lph_pkg::mix_r56(r_mix2[2]);
        end
    end

    assign o_hash.valid     = r_vld[NS-1];
    assign o_hash.hash_word = r_hash;

endmodule

### rtl/lph_chk.sv
// lph_chk: port-level checks on the landmark pair hash, bound to the top
// depends on lph_pkg and landmark_pair_hash
module lph_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input lph_pkg::t_word i_hash_word
);
    // a stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_hash_word))
        else $error("output word changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output word valid straight after reset");

    // with nothing waiting at the output the pipeline cannot be full
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held off with an empty output");

endmodule

bind landmark_pair_hash lph_chk u_lph_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_hash.valid),
    .i_out_ready (o_hash.ready),
    .i_hash_word (o_hash.hash_word)
);
